### rtl/mlr_pkg.sv
// shared types and constants for the midpoint line rasterizer
// used by every module of the block, no dependencies

package mlr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int DEC_W       = COORD_BITS + 3;
  localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_W-1:0] dec_t;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    MODE_VERT         = 3'd0,
    MODE_HORIZ        = 3'd1,
    MODE_SHALLOW_UP   = 3'd2,
    MODE_STEEP_UP     = 3'd3,
    MODE_SHALLOW_DOWN = 3'd4,
    MODE_STEEP_DOWN   = 3'd5
  } line_mode_t;

  // one classified word handed from the front to the back
  typedef struct packed {
    action_t    action;
    line_mode_t mode;
    coord_t     x0;
    coord_t     y0;
    coord_t     x1;
    coord_t     y1;
    dec_t       decision;
    dec_t       inc_a;
    dec_t       inc_b;
  } q_entry_t;

endpackage

### rtl/mlr_front.sv
// front end: takes input words, orders endpoints, picks the octant and
// sets up the decision terms; depends on mlr_pkg

module mlr_front (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mlr_pkg::IN_TDATA_W-1:0]     in_tdata,  // start_x, start_y, finish_x, finish_y
  input  logic                               in_tuser,  // action
  output logic                               push_valid,
  input  logic                               push_ready,
  output mlr_pkg::q_entry_t                  push_entry
);

  localparam int CB = mlr_pkg::COORD_BITS;

  mlr_pkg::coord_t sx, sy, fx, fy;
  mlr_pkg::coord_t x0, y0, x1, y1;
  mlr_pkg::dec_t   dx, dy, ndy;

  assign sx = in_tdata[CB-1:0];
  assign sy = in_tdata[2*CB-1:CB];
  assign fx = in_tdata[3*CB-1:2*CB];
  assign fy = in_tdata[4*CB-1:3*CB];

  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

  always_comb begin
    // order so that x does not decrease
    if (sx > fx) begin
      x0 = fx; y0 = fy; x1 = sx; y1 = sy;
    end else begin
      x0 = sx; y0 = sy; x1 = fx; y1 = fy;
    end
    dx  = mlr_pkg::dec_t'(x1) - mlr_pkg::dec_t'(x0);
    dy  = mlr_pkg::dec_t'(y1) - mlr_pkg::dec_t'(y0);
    ndy = -dy;

    push_entry          = '0;
    push_entry.action   = mlr_pkg::action_t'(in_tuser);
    push_entry.x0       = x0;
    push_entry.y0       = y0;
    push_entry.x1       = x1;
    push_entry.y1       = y1;

    priority if (dx == '0) begin
      push_entry.mode = mlr_pkg::MODE_VERT;
      // vertical lines run upward in y
      if (y0 > y1) begin
        push_entry.y0 = y1;
        push_entry.y1 = y0;
      end
    end else if (dy == '0) begin
      push_entry.mode = mlr_pkg::MODE_HORIZ;
    end else if (!dy[mlr_pkg::DEC_W-1] && dx >= dy) begin
      push_entry.mode     = mlr_pkg::MODE_SHALLOW_UP;
      push_entry.decision = (dy <<< 1) - dx;
      push_entry.inc_a    = dy <<< 1;
      push_entry.inc_b    = (dy - dx) <<< 1;
    end else if (!dy[mlr_pkg::DEC_W-1]) begin
      push_entry.mode     = mlr_pkg::MODE_STEEP_UP;
      push_entry.decision = (dx <<< 1) - dy;
      push_entry.inc_a    = dx <<< 1;
      push_entry.inc_b    = (dx - dy) <<< 1;
    end else if (dx >= ndy) begin
      push_entry.mode     = mlr_pkg::MODE_SHALLOW_DOWN;
      push_entry.decision = (dy <<< 1) + dx;
      push_entry.inc_a    = dy <<< 1;
      push_entry.inc_b    = (dy + dx) <<< 1;
    end else begin
      push_entry.mode     = mlr_pkg::MODE_STEEP_DOWN;
      push_entry.decision = (dx <<< 1) + dy;
      push_entry.inc_a    = dx <<< 1;
      push_entry.inc_b    = (dx + dy) <<< 1;
    end
  end

endmodule

### rtl/mlr_queue.sv
// two-entry queue of classified words between front and back
// depends on mlr_pkg

module mlr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  mlr_pkg::q_entry_t push_entry,
  output logic              pop_valid,
  input  logic              pop_ready,
  output mlr_pkg::q_entry_t pop_entry
);

  mlr_pkg::q_entry_t                   mem_r [mlr_pkg::QDEPTH];
  logic [mlr_pkg::QPTR_W-1:0]          wr_ptr_r, rd_ptr_r;
  logic [mlr_pkg::QCNT_W-1:0]          count_r, count_nxt;
  logic                                do_push, do_pop;

  assign push_ready = (count_r != mlr_pkg::QCNT_W'(mlr_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mlr_pkg::QCNT_W'(mlr_pkg::QDEPTH))
    else $error("queue count above depth");
`endif

endmodule

### rtl/mlr_back.sv
// back end: holds the segment state, runs the midpoint step and keeps the
// output register; depends on mlr_pkg

module mlr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  mlr_pkg::q_entry_t                 q_entry,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mlr_pkg::OUT_TDATA_W-1:0]   out_tdata,  // pixel_x, pixel_y
  output logic                              out_tuser,  // pixel_valid
  output logic                              out_tlast   // last_pixel
);

  mlr_pkg::coord_t     cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  mlr_pkg::coord_t     cur_x_nxt, cur_y_nxt, tgt_x_nxt, tgt_y_nxt;
  mlr_pkg::dec_t       dec_r, inc_a_r, inc_b_r;
  mlr_pkg::dec_t       dec_nxt, inc_a_nxt, inc_b_nxt;
  mlr_pkg::line_mode_t mode_r, mode_nxt;
  logic                busy_r, busy_nxt;

  mlr_pkg::coord_t     pix_x_r, pix_y_r, pix_x_nxt, pix_y_nxt;
  logic                pvalid_r, plast_r, pvalid_nxt, plast_nxt;
  logic                out_valid_r;
  logic                fire, dec_le0, last;

  assign fire    = q_valid && (!out_valid_r || out_tready);
  assign q_pop   = fire;
  assign dec_le0 = dec_r[mlr_pkg::DEC_W-1] || (dec_r == '0);

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    dec_nxt    = dec_r;
    inc_a_nxt  = inc_a_r;
    inc_b_nxt  = inc_b_r;
    mode_nxt   = mode_r;
    busy_nxt   = busy_r;
    pix_x_nxt  = '0;
    pix_y_nxt  = '0;
    pvalid_nxt = 1'b0;
    plast_nxt  = 1'b0;
    last       = 1'b0;

    if (q_entry.action == mlr_pkg::ACT_START) begin
      cur_x_nxt  = q_entry.x0;
      cur_y_nxt  = q_entry.y0;
      tgt_x_nxt  = q_entry.x1;
      tgt_y_nxt  = q_entry.y1;
      dec_nxt    = q_entry.decision;
      inc_a_nxt  = q_entry.inc_a;
      inc_b_nxt  = q_entry.inc_b;
      mode_nxt   = q_entry.mode;
      last       = (q_entry.x0 == q_entry.x1) && (q_entry.y0 == q_entry.y1);
      busy_nxt   = !last;
      pix_x_nxt  = q_entry.x0;
      pix_y_nxt  = q_entry.y0;
      pvalid_nxt = 1'b1;
      plast_nxt  = last;
    end else if (busy_r) begin
      pvalid_nxt = 1'b1;
      unique case (mode_r)
        mlr_pkg::MODE_VERT: begin
          cur_y_nxt = cur_y_r + 1'b1;
          last      = (cur_y_nxt == tgt_y_r);
        end
        mlr_pkg::MODE_HORIZ: begin
          cur_x_nxt = cur_x_r + 1'b1;
          last      = (cur_x_nxt == tgt_x_r);
        end
        mlr_pkg::MODE_SHALLOW_UP: begin
          if (dec_le0) begin
            dec_nxt = dec_r + inc_a_r;
          end else begin
            dec_nxt   = dec_r + inc_b_r;
            cur_y_nxt = cur_y_r + 1'b1;
          end
          cur_x_nxt = cur_x_r + 1'b1;
          last      = (cur_x_nxt == tgt_x_r);
        end
        mlr_pkg::MODE_STEEP_UP: begin
          if (dec_le0) begin
            dec_nxt = dec_r + inc_a_r;
          end else begin
            dec_nxt   = dec_r + inc_b_r;
            cur_x_nxt = cur_x_r + 1'b1;
          end
          cur_y_nxt = cur_y_r + 1'b1;
          last      = (cur_y_nxt == tgt_y_r);
        end
        mlr_pkg::MODE_SHALLOW_DOWN: begin
          // mirrored rule: straight while the decision is positive
          if (!dec_le0) begin
            dec_nxt = dec_r + inc_a_r;
          end else begin
            dec_nxt   = dec_r + inc_b_r;
            cur_y_nxt = cur_y_r - 1'b1;
          end
          cur_x_nxt = cur_x_r + 1'b1;
          last      = (cur_x_nxt == tgt_x_r);
        end
        mlr_pkg::MODE_STEEP_DOWN: begin
          if (dec_le0) begin
            dec_nxt = dec_r + inc_a_r;
          end else begin
            dec_nxt   = dec_r + inc_b_r;
            cur_x_nxt = cur_x_r + 1'b1;
          end
          cur_y_nxt = cur_y_r - 1'b1;
          last      = (cur_y_nxt == tgt_y_r);
        end
        default: begin
          busy_nxt   = 1'b0;
          pvalid_nxt = 1'b0;
        end
      endcase
      if (pvalid_nxt) begin
        if (last) busy_nxt = 1'b0;
        pix_x_nxt = cur_x_nxt;
        pix_y_nxt = cur_y_nxt;
        plast_nxt = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        busy_r      <= busy_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      tgt_x_r  <= tgt_x_nxt;
      tgt_y_r  <= tgt_y_nxt;
      dec_r    <= dec_nxt;
      inc_a_r  <= inc_a_nxt;
      inc_b_r  <= inc_b_nxt;
      mode_r   <= mode_nxt;
      pix_x_r  <= pix_x_nxt;
      pix_y_r  <= pix_y_nxt;
      pvalid_r <= pvalid_nxt;
      plast_r  <= plast_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = mlr_pkg::OUT_TDATA_W'({pix_y_r, pix_x_r});
  assign out_tuser  = pvalid_r;
  assign out_tlast  = plast_r;

`ifndef SYNTHESIS
  a_idle_step_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (q_entry.action == mlr_pkg::ACT_STEP) && !busy_r
      |=> !out_tuser && !out_tlast && (out_tdata == '0))
    else $error("step while idle produced a pixel");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last flag without a valid pixel");

  a_last_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && plast_nxt |=> !busy_r)
    else $error("segment still busy after its last pixel");
`endif

endmodule

### rtl/midpoint_line_rasterizer_unit.sv
// midpoint line rasterizer: streaming input of start/step words, one
// pixel word out for each input word.
//
// in_*  : in_tuser is the action (0 start a segment, 1 step to the next
//         pixel); in_tdata carries start_x, start_y, finish_x, finish_y.
// out_* : out_tdata carries pixel_x, pixel_y; out_tuser is pixel_valid
//         (low when a step arrives with no segment active, coordinates
//         then zero); out_tlast marks the segment's final endpoint.
// a start word yields the first pixel at once; each step word yields the
// next pixel. a start while a segment runs drops the old segment.
// with the queue empty, an input word that is taken is first written into the
// queue and from there loads the output register, which drives out_tvalid.
// throughput: one word per clock while the output is not stalled; the back
// end computes each midpoint step combinationally into its registers.
// reset: the queue empties, out_tvalid clears and the block is idle with no
// segment active.
// when out_tready is low the output register holds its word, the two-entry
// queue fills, and in_tready drops once both entries are taken.
// depends on mlr_pkg, mlr_front, mlr_queue, mlr_back

module midpoint_line_rasterizer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mlr_pkg::IN_TDATA_W-1:0]    in_tdata,   // start_x, start_y, finish_x, finish_y
  input  logic                              in_tuser,   // action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mlr_pkg::OUT_TDATA_W-1:0]   out_tdata,  // pixel_x, pixel_y
  output logic                              out_tuser,  // pixel_valid
  output logic                              out_tlast   // last_pixel
);

  logic              push_valid, push_ready, pop_valid, pop_ready;
  mlr_pkg::q_entry_t push_entry, pop_entry;

  mlr_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  mlr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  mlr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_pop      (pop_ready),
    .q_entry    (pop_entry),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
